// ===== hw/rtl/oaks_pkg.sv =====
// ----------------------------------------------------------------------------
// oaks_pkg
// Shared types and constants for the ordered array key set: operation codes,
// field widths, default sizes and the memory request bundle.
// ----------------------------------------------------------------------------
package oaks_pkg;

  // operation codes carried in the kind field
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_LOOKUP = 2'd2;
  localparam kind_t KIND_CLEAR  = 2'd3;

  // fixed field widths of the channels
  localparam int IN_KEY_W = 32;
  localparam int COUNT_W  = 5;

  // default sizes
  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_KEY_WIDTH = 32;

  // upper bounds of the sizes, used for the request bundle
  localparam int MAX_ADDR_W = 10;
  localparam int MAX_KEY_W  = 64;

  // read and write port requests from the sequencer
  typedef struct packed {
    logic                  rd_en;
    logic [MAX_ADDR_W-1:0] rd_addr;
    logic                  wr_en;
    logic [MAX_ADDR_W-1:0] wr_addr;
    logic [MAX_KEY_W-1:0]  wr_data;
  } mem_req_t;

endpackage

// ===== hw/rtl/oaks_ifs.sv =====
// ----------------------------------------------------------------------------
// oaks_ifs
// Valid/ready channels of the key set: the request word (kind, key) and the
// result word (found, dropped_full, count).
// ----------------------------------------------------------------------------
interface oaks_in_if;
  import oaks_pkg::*;

  logic                valid;
  logic                ready;
  kind_t               kind;
  logic [IN_KEY_W-1:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

interface oaks_out_if;
  import oaks_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic               dropped_full;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output found, output dropped_full, output count, input ready);
  modport sink   (input valid, input found, input dropped_full, input count, output ready);
endinterface

// ===== hw/rtl/oaks_mem.sv =====
// ----------------------------------------------------------------------------
// oaks_mem
// Key store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module oaks_mem #(
  parameter int CAPACITY  = oaks_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = oaks_pkg::DEF_KEY_WIDTH
) (
  input  logic                 clk,
  input  oaks_pkg::mem_req_t   req,
  output logic [KEY_WIDTH-1:0] rd_data
);
  import oaks_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [KEY_WIDTH-1:0] mem_r [CAPACITY];
  logic [KEY_WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr[AW-1:0]] <= req.wr_data[KEY_WIDTH-1:0];
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/oaks_ctrl.sv =====
// ----------------------------------------------------------------------------
// oaks_ctrl
// Sequencer of the key set: linear search over the held entries, shift-down
// pass on remove, append on insert, count keeping and the result register.
// ----------------------------------------------------------------------------
module oaks_ctrl #(
  parameter int CAPACITY  = oaks_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = oaks_pkg::DEF_KEY_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  oaks_in_if.sink              in_ch,
  oaks_out_if.source           out_ch,
  output oaks_pkg::mem_req_t   req,
  input  logic [KEY_WIDTH-1:0] rd_data
);
  import oaks_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SRCH  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]           st_r, st_nxt;
  kind_t                kind_r, kind_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 found_r, found_nxt;
  logic [CW-1:0]        held_r, held_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic                 out_drop_r, out_drop_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic [IN_KEY_W+KEY_WIDTH-1:0] key_ext;
  logic [KEY_WIDTH-1:0]          key_in;
  logic [CW:0]                   held_ext, idx1, idx2;
  logic [COUNT_W+CW-1:0]         count_ext;
  logic                          is_full, match, fin_go, drop;

  // key masked to the stored width
  assign key_ext = {{KEY_WIDTH{1'b0}}, in_ch.key};
  assign key_in  = key_ext[KEY_WIDTH-1:0];

  assign held_ext  = {1'b0, held_r};
  assign idx1      = {1'b0, idx_r} + 1'b1;
  assign idx2      = {1'b0, idx_r} + 2'd2;
  assign is_full   = (held_r >= CW'(CAPACITY));
  assign match     = (rd_data == key_r);
  assign fin_go    = (st_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign drop      = (kind_r == KIND_INSERT) && !found_r && is_full;
  assign count_ext = {{COUNT_W{1'b0}}, held_nxt};

  assign in_ch.ready = (st_r == ST_IDLE);

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_drop_nxt  = out_drop_r;
    out_count_nxt = out_count_r;
    req           = '0;

    // result word taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = in_ch.kind;
          key_nxt   = key_in;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if (held_r != '0) begin
            req.rd_en   = 1'b1;
            req.rd_addr = '0;
            st_nxt      = ST_SRCH;
          end else begin
            st_nxt = ST_FIN;
          end
        end
      end
      // one entry compared per cycle
      ST_SRCH: begin
        if (match) begin
          found_nxt = 1'b1;
          if ((kind_r == KIND_REMOVE) && (idx1 < held_ext)) begin
            req.rd_en   = 1'b1;
            req.rd_addr = MAX_ADDR_W'(idx1);
            st_nxt      = ST_SHIFT;
          end else begin
            st_nxt = ST_FIN;
          end
        end else if (idx1 < held_ext) begin
          req.rd_en   = 1'b1;
          req.rd_addr = MAX_ADDR_W'(idx1);
          idx_nxt     = idx1[CW-1:0];
        end else begin
          st_nxt = ST_FIN;
        end
      end
      // entry idx+1 arrives, written to idx
      ST_SHIFT: begin
        req.wr_en   = 1'b1;
        req.wr_addr = MAX_ADDR_W'(idx_r);
        req.wr_data = MAX_KEY_W'(rd_data);
        if (idx2 < held_ext) begin
          req.rd_en   = 1'b1;
          req.rd_addr = MAX_ADDR_W'(idx2);
          idx_nxt     = idx1[CW-1:0];
        end else begin
          st_nxt = ST_FIN;
        end
      end
      // commit count, append and load the result word
      ST_FIN: begin
        if (fin_go) begin
          case (kind_r)
            KIND_INSERT: begin
              if (!found_r && !is_full) begin
                req.wr_en   = 1'b1;
                req.wr_addr = MAX_ADDR_W'(held_r);
                req.wr_data = MAX_KEY_W'(key_r);
                held_nxt    = CW'(held_ext + 1'b1);
              end
            end
            KIND_REMOVE: begin
              if (found_r) begin
                held_nxt = CW'(held_ext - 1'b1);
              end
            end
            KIND_CLEAR: held_nxt = '0;
            default: ;
          endcase
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_drop_nxt  = drop;
          out_count_nxt = count_ext[COUNT_W-1:0];
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    idx_r       <= idx_nxt;
    found_r     <= found_nxt;
    out_found_r <= out_found_nxt;
    out_drop_r  <= out_drop_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.dropped_full = out_drop_r;
  assign out_ch.count        = out_count_r;

`ifndef NO_ASSERTIONS
  // count never passes the capacity
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(CAPACITY))
    else $error("held count above capacity");

  // search cycles never write the store
  a_srch_no_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SRCH) |-> !req.wr_en)
    else $error("store written during search");

  // shift writes stay below the last held entry
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SHIFT) |-> (idx1 < held_ext))
    else $error("shift outside held entries");

  // a successful remove lowers the count by one
  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && (kind_r == KIND_REMOVE) && found_r) |=>
      (held_r == CW'($past(held_ext) - 1'b1)))
    else $error("remove did not lower the count");

  // a dropped insert leaves the store full
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drop_r) |-> (held_r == CW'(CAPACITY)))
    else $error("insert dropped below capacity");
`endif

endmodule

// ===== hw/rtl/ordered_array_key_set.sv =====
// ----------------------------------------------------------------------------
// ordered_array_key_set
// Set of distinct keys kept in insertion order in a fixed on-chip store.
// ----------------------------------------------------------------------------
// Each request word carries an operation (insert, remove, lookup, clear) and a
// key; each one gives exactly one result word with found, dropped_full and the
// count after the operation. Keys live in one memory with a registered read;
// the sequencer compares one held entry per cycle, and a remove then moves
// every later entry down one place, one entry per cycle through the same read
// and write ports. The search stops at a match and otherwise compares every
// held entry. A result is loaded only once the previous result word has left
// the output register.
// A new request is taken once the previous one has finished; its result may
// still wait in the output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module ordered_array_key_set #(
  parameter int CAPACITY  = oaks_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = oaks_pkg::DEF_KEY_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  oaks_in_if.sink    in_ch,
  oaks_out_if.source out_ch
);
  import oaks_pkg::*;

  mem_req_t             req;
  logic [KEY_WIDTH-1:0] rd_data;

  // sequencer
  oaks_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .req     (req),
    .rd_data (rd_data)
  );

  // key store
  oaks_mem #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

// ===== bench/tb_ordered_array_key_set.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_array_key_set
// Self-checking bench for the ordered array key set. A directed sequence
// covers empty, full, duplicate, remove and clear cases. Random words then
// draw keys mostly from a small changing pool, so that the set fills,
// drains and overflows often. Each accepted request word is run through
// a local copy of the set to give the expected result word, and the
// monitor compares every result word with it under random stalls on
// both sides.
// ----------------------------------------------------------------------------
module tb_ordered_array_key_set;
  import oaks_pkg::*;

  localparam int CAP       = DEF_CAPACITY;
  localparam int N_RANDOM  = 1523;
  localparam int POOL_MAX  = 24;
  localparam int STALL_AT  = 300;
  localparam int STALL_LEN = 250;

  typedef struct {
    kind_t               kind;
    logic [IN_KEY_W-1:0] key;
    bit                  drain_first;
  } req_t;

  typedef struct {
    logic               found;
    logic               dropped_full;
    logic [COUNT_W-1:0] count;
  } set_result_t;

  logic clk = 1'b0;
  logic rst_n;

  oaks_in_if  in_ch ();
  oaks_out_if out_ch ();

  ordered_array_key_set u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // local copy of the set contents
  logic [IN_KEY_W-1:0] shadow_keys [CAP];
  int unsigned         shadow_held;

  req_t        req_queue[$];
  set_result_t result_queue[$];
  int          words_in;
  int          words_out;
  int          errors;
  int          stall_left;
  bit          stall_done;

  logic [IN_KEY_W-1:0] key_pool [POOL_MAX];
  int                  pool_n;

  // apply one operation to the local set and queue the expected word
  function automatic void apply_set_op(kind_t kind, logic [IN_KEY_W-1:0] key);
    set_result_t r;
    int          slot;
    slot = -1;
    for (int i = 0; i < shadow_held; i++) begin
      if (slot < 0 && shadow_keys[i] == key) slot = i;
    end
    r.found        = (slot >= 0);
    r.dropped_full = 1'b0;
    case (kind)
      KIND_INSERT: begin
        if (slot < 0) begin
          if (shadow_held >= CAP) begin
            r.dropped_full = 1'b1;
          end else begin
            shadow_keys[shadow_held] = key;
            shadow_held++;
          end
        end
      end
      KIND_REMOVE: begin
        if (slot >= 0) begin
          for (int i = slot; i + 1 < shadow_held; i++) shadow_keys[i] = shadow_keys[i + 1];
          shadow_held--;
        end
      end
      KIND_LOOKUP: begin
      end
      default: begin
        shadow_held = 0;
      end
    endcase
    r.count = shadow_held[COUNT_W-1:0];
    result_queue.push_back(r);
  endfunction

  function automatic void push_req(kind_t kind, logic [IN_KEY_W-1:0] key, bit drain_first);
    req_t q;
    q.kind        = kind;
    q.key         = key;
    q.drain_first = drain_first;
    req_queue.push_back(q);
  endfunction

  // idle rates per phase: sender light first, then receiver light, then none
  function automatic int send_idle_pct();
    return (words_in < 600) ? 24 : (words_in < 1200) ? 66 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return (words_in < 600) ? 66 : (words_in < 1200) ? 24 : 0;
  endfunction

  // request driver
  always @(posedge clk) begin
    req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_set_op(in_ch.kind, in_ch.key);
        words_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (req_queue.size() != 0 && !(req_queue[0].drain_first && result_queue.size() != 0)
            && $urandom_range(0, 99) >= send_idle_pct()) begin
          nxt = req_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.kind  <= nxt.kind;
          in_ch.key   <= nxt.key;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the block backs up into the request side
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && words_out >= STALL_AT) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    set_result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result word found=%0b dropped_full=%0b count=%0d",
                   $time, out_ch.found, out_ch.dropped_full, out_ch.count);
          errors++;
        end else begin
          exp_r = result_queue.pop_front();
          if (out_ch.found !== exp_r.found) begin
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, exp_r.found, out_ch.found);
            errors++;
          end
          if (out_ch.dropped_full !== exp_r.dropped_full) begin
            $display("%0t: dropped_full mismatch, expected %0b actual %0b",
                     $time, exp_r.dropped_full, out_ch.dropped_full);
            errors++;
          end
          if (out_ch.count !== exp_r.count) begin
            $display("%0t: count mismatch, expected %0d actual %0d",
                     $time, exp_r.count, out_ch.count);
            errors++;
          end
        end
      end
      out_ch.ready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  // stimulus and end of run
  initial begin
    int   r;
    int   k;
    logic [IN_KEY_W-1:0] key;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_INSERT;
    in_ch.key    = '0;
    out_ch.ready = 1'b0;
    words_in     = 0;
    words_out    = 0;
    errors       = 0;
    shadow_held  = 0;

    // directed: empty set, key extremes, duplicates, full store, removes, clears
    push_req(KIND_LOOKUP, 32'h0000_0000, 1'b0);
    push_req(KIND_REMOVE, 32'h0000_0000, 1'b0);
    push_req(KIND_INSERT, 32'h0000_0000, 1'b0);
    push_req(KIND_INSERT, 32'hFFFF_FFFF, 1'b0);
    push_req(KIND_INSERT, 32'h0000_0000, 1'b0);
    for (int i = 0; i < CAP - 2; i++) push_req(KIND_INSERT, 32'h1000_0001 << i, 1'b0);
    push_req(KIND_INSERT, 32'hA5A5_5A5A, 1'b0);
    push_req(KIND_INSERT, 32'hFFFF_FFFF, 1'b0);
    push_req(KIND_REMOVE, 32'h1000_0001 << 5, 1'b0);
    push_req(KIND_REMOVE, 32'h0000_0000, 1'b0);
    push_req(KIND_REMOVE, 32'h1000_0001 << (CAP - 3), 1'b0);
    push_req(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0);
    push_req(KIND_CLEAR,  32'hFFFF_FFFF, 1'b0);
    push_req(KIND_CLEAR,  32'h1234_5678, 1'b0);

    // random: pooled keys so hits, fills and overflows are common
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        pool_n = $urandom_range(8, POOL_MAX);
        for (int j = 0; j < POOL_MAX; j++) key_pool[j] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
      end
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 9);
      key = (k == 0) ? $urandom() : key_pool[$urandom_range(0, pool_n - 1)];
      push_req((r < 50) ? KIND_INSERT : (r < 72) ? KIND_REMOVE :
               (r < 98) ? KIND_LOOKUP : KIND_CLEAR, key, (n == 700));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() != 0 || in_ch.valid || result_queue.size() != 0) @(posedge clk);
    repeat (2 * CAP + 8) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/oaks_pkg.sv
hw/rtl/oaks_ifs.sv
hw/rtl/oaks_mem.sv
hw/rtl/oaks_ctrl.sv
hw/rtl/ordered_array_key_set.sv
bench/tb_ordered_array_key_set.sv
